// ===== src/hsv2rgb_pkg.sv =====
// Types and constants shared by the HSV to RGB converter.
// No dependencies; every other file of the block depends on this package.
package hsv2rgb_pkg;

  localparam int HUE_W = 16;
  localparam int Q8_W  = 9;
  localparam int CH_W  = 8;
  localparam int NUM_W = 22;

  localparam logic [Q8_W-1:0] FULL_Q8    = 9'd256;
  localparam logic [8:0]      DEG_FULL   = 9'd360;
  localparam logic [5:0]      DEG_SECTOR = 6'd60;
  localparam logic [13:0]     ONE_NUM    = 14'd15360;   // 256 * 60
  // Offsetting the hue by 2^15 turns it unsigned; 2^15 mod 360 = 8, so adding
  // 360 - 8 keeps the residue unchanged.
  localparam logic [16:0]     HUE_BIAS   = 17'd352;
  localparam logic [13:0]     RECIP45    = 14'd11651;   // ceil(2^19 / 45)
  localparam logic [14:0]     RECIP15    = 15'd17477;   // ceil(2^18 / 15)

  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;

  // Hue reduced to sector and remainder, with the clamped operands.
  typedef struct packed {
    logic            valid;
    logic [2:0]      sector;
    logic [5:0]      rem;
    logic [Q8_W-1:0] sat;
    logic [Q8_W-1:0] val;
  } hsv_sec_t;

  // Numerators of v, p, q and t over the denominator 256 * 256 * 60.
  typedef struct packed {
    logic             valid;
    logic [2:0]       sector;
    logic [NUM_W-1:0] n_v;
    logic [NUM_W-1:0] n_p;
    logic [NUM_W-1:0] n_q;
    logic [NUM_W-1:0] n_t;
  } hsv_num_t;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_pix_t;

endpackage

// ===== src/hsv2rgb_if.sv =====
// Valid/ready channel interfaces for the HSV input and the RGB output.
// Depends on hsv2rgb_pkg for the field widths.
interface hsv_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [hsv2rgb_pkg::HUE_W-1:0]      hue_degrees;
  logic        [hsv2rgb_pkg::Q8_W-1:0]       brightness;
  modport source (output valid, hue_degrees, brightness, input ready);
  modport sink   (input valid, hue_degrees, brightness, output ready);
endinterface

interface rgb_if;
  logic                               valid;
  logic                               ready;
  logic [hsv2rgb_pkg::CH_W-1:0]      red;
  logic [hsv2rgb_pkg::CH_W-1:0]      green;
  logic [hsv2rgb_pkg::CH_W-1:0]      blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== src/hsv2rgb_hue_wrap.sv =====
// Three pipeline stages: hue modulo 360, then sector and remainder within it.
// Depends on hsv2rgb_pkg.
module hsv2rgb_hue_wrap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic signed [hsv2rgb_pkg::HUE_W-1:0]  hue,
  input  logic        [hsv2rgb_pkg::Q8_W-1:0]   val_in,
  input  logic        [hsv2rgb_pkg::Q8_W-1:0]   sat_in,
  output hsv2rgb_pkg::hsv_sec_t                 sec_out
);
  import hsv2rgb_pkg::*;

  // Stage A: biased hue and reciprocal product for the division by 360.
  logic            a_valid;
  logic [16:0]     a_x;
  logic [27:0]     a_prod;
  logic [Q8_W-1:0] a_sat;
  logic [Q8_W-1:0] a_val;
  logic [16:0]     x_next;

  assign x_next = {1'b0, ~hue[15], hue[14:0]} + HUE_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x    <= x_next;
      a_prod <= 28'(x_next[16:3]) * 28'(RECIP45);
      a_sat  <= (sat_in > FULL_Q8) ? FULL_Q8 : sat_in;
      a_val  <= (val_in > FULL_Q8) ? FULL_Q8 : val_in;
    end
  end

  // Stage B: remainder x - 360 * q, corrected once.
  logic            b_valid;
  logic [8:0]      b_h;
  logic [Q8_W-1:0] b_sat;
  logic [Q8_W-1:0] b_val;
  logic [16:0]     r_raw;
  logic [16:0]     r_fix;

  assign r_raw = a_x - 17'(a_prod[27:19]) * 17'(DEG_FULL);
  assign r_fix = (r_raw >= 17'(DEG_FULL)) ? r_raw - 17'(DEG_FULL) : r_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_h   <= r_fix[8:0];
      b_sat <= a_sat;
      b_val <= a_val;
    end
  end

  // Stage C: sector by comparison against the sector boundaries.
  logic [2:0] sector_next;
  logic [8:0] base;
  logic [8:0] rem_wide;

  always_comb begin
    priority if (b_h >= 9'd300) begin
      sector_next = SECTOR_5;
      base        = 9'd300;
    end else if (b_h >= 9'd240) begin
      sector_next = SECTOR_4;
      base        = 9'd240;
    end else if (b_h >= 9'd180) begin
      sector_next = SECTOR_3;
      base        = 9'd180;
    end else if (b_h >= 9'd120) begin
      sector_next = SECTOR_2;
      base        = 9'd120;
    end else if (b_h >= 9'(DEG_SECTOR)) begin
      sector_next = SECTOR_1;
      base        = 9'(DEG_SECTOR);
    end else begin
      sector_next = SECTOR_0;
      base        = 9'd0;
    end
  end

  assign rem_wide = b_h - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_out.valid <= 1'b0;
    end else if (adv) begin
      sec_out.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec_out.sector <= sector_next;
      sec_out.rem    <= rem_wide[5:0];
      sec_out.sat    <= b_sat;
      sec_out.val    <= b_val;
    end
  end

endmodule

// ===== src/hsv2rgb_terms.sv =====
// Two pipeline stages forming the exact numerators of v, p, q and t.
// Depends on hsv2rgb_pkg.
module hsv2rgb_terms (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  hsv2rgb_pkg::hsv_sec_t sec_in,
  output hsv2rgb_pkg::hsv_num_t num_out
);
  import hsv2rgb_pkg::*;

  // Stage D: the factors (1 - s), (1 - s f) and (1 - s (1 - f)), scaled by 256 * 60.
  logic            d_valid;
  logic [2:0]      d_sector;
  logic [Q8_W-1:0] d_val;
  logic [13:0]     d_ap;
  logic [13:0]     d_aq;
  logic [13:0]     d_at;
  logic [14:0]     sq_prod;
  logic [14:0]     st_prod;
  logic [14:0]     ap_prod;
  logic [14:0]     aq_wide;
  logic [14:0]     at_wide;

  assign sq_prod = 15'(sec_in.sat) * 15'(sec_in.rem);
  assign st_prod = 15'(sec_in.sat) * 15'(DEG_SECTOR - sec_in.rem);
  assign ap_prod = 15'(FULL_Q8 - sec_in.sat) * 15'(DEG_SECTOR);
  assign aq_wide = 15'(ONE_NUM) - sq_prod;
  assign at_wide = 15'(ONE_NUM) - st_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= sec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sector <= sec_in.sector;
      d_val    <= sec_in.val;
      d_ap     <= ap_prod[13:0];
      d_aq     <= aq_wide[13:0];
      d_at     <= at_wide[13:0];
    end
  end

  // Stage E: multiply each factor by the brightness.
  logic [22:0] nv_wide;
  logic [22:0] np_wide;
  logic [22:0] nq_wide;
  logic [22:0] nt_wide;

  assign nv_wide = 23'(d_val) * 23'(ONE_NUM);
  assign np_wide = 23'(d_val) * 23'(d_ap);
  assign nq_wide = 23'(d_val) * 23'(d_aq);
  assign nt_wide = 23'(d_val) * 23'(d_at);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_out.valid <= 1'b0;
    end else if (adv) begin
      num_out.valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_out.sector <= d_sector;
      num_out.n_v    <= nv_wide[NUM_W-1:0];
      num_out.n_p    <= np_wide[NUM_W-1:0];
      num_out.n_q    <= nq_wide[NUM_W-1:0];
      num_out.n_t    <= nt_wide[NUM_W-1:0];
    end
  end

endmodule

// ===== src/hsv2rgb_scale.sv =====
// Three pipeline stages: floor(n * 255 / (256 * 256 * 60)) per term, then the
// sector mapping onto red, green and blue. Depends on hsv2rgb_pkg.
module hsv2rgb_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  hsv2rgb_pkg::hsv_num_t num_in,
  output hsv2rgb_pkg::rgb_pix_t pix_out
);
  import hsv2rgb_pkg::*;

  // The denominator is 2^18 * 15: shift first, then divide by 15 by reciprocal.
  logic [NUM_W-1:0] nums [4];
  assign nums[0] = num_in.n_v;
  assign nums[1] = num_in.n_p;
  assign nums[2] = num_in.n_q;
  assign nums[3] = num_in.n_t;

  logic       f_valid;
  logic [2:0] f_sector;
  logic [11:0] f_m [4];
  logic       g_valid;
  logic [2:0] g_sector;
  logic [28:0] g_p [4];
  logic [CH_W-1:0] ch [4];
  logic [29:0] times255 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      times255[i] = {nums[i], 8'd0} - 30'(nums[i]);
      ch[i]       = g_p[i][25:18];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= num_in.valid;
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_sector <= num_in.sector;
      g_sector <= f_sector;
      for (int i = 0; i < 4; i++) begin
        f_m[i] <= times255[i][29:18];
        g_p[i] <= 29'(f_m[i]) * 29'(RECIP15);
      end
    end
  end

  // Stage H: sector mapping. Channel order in ch is v, p, q, t.
  logic [CH_W-1:0] r_sel;
  logic [CH_W-1:0] g_sel;
  logic [CH_W-1:0] b_sel;

  always_comb begin
    unique case (g_sector)
      SECTOR_1: begin r_sel = ch[2]; g_sel = ch[0]; b_sel = ch[1]; end
      SECTOR_2: begin r_sel = ch[1]; g_sel = ch[0]; b_sel = ch[3]; end
      SECTOR_3: begin r_sel = ch[1]; g_sel = ch[2]; b_sel = ch[0]; end
      SECTOR_4: begin r_sel = ch[3]; g_sel = ch[1]; b_sel = ch[0]; end
      SECTOR_5: begin r_sel = ch[0]; g_sel = ch[1]; b_sel = ch[2]; end
      default:  begin r_sel = ch[0]; g_sel = ch[3]; b_sel = ch[1]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      pix_out.valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out.red   <= r_sel;
      pix_out.green <= g_sel;
      pix_out.blue  <= b_sel;
    end
  end

endmodule

// ===== src/hsv2rgb_skid.sv =====
// Two-entry output skid buffer; its registered space flag advances the pipeline.
// Depends on hsv2rgb_pkg and the rgb_if interface.
module hsv2rgb_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  hsv2rgb_pkg::rgb_pix_t pix_in,
  output logic                  adv,
  rgb_if.source                 rgb
);
  import hsv2rgb_pkg::*;

  logic            main_valid;
  logic            spare_valid;
  logic [CH_W-1:0] main_r, main_g, main_b;
  logic [CH_W-1:0] spare_r, spare_g, spare_b;
  logic            push;
  logic            pop;

  assign adv  = ~spare_valid;
  assign push = adv & pix_in.valid;
  assign pop  = main_valid & rgb.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (pop) begin
        spare_valid <= 1'b0;
      end
    end else if (!main_valid || pop) begin
      main_valid <= push;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (pop) begin
        main_r <= spare_r;
        main_g <= spare_g;
        main_b <= spare_b;
      end
    end else if (!main_valid || pop) begin
      main_r <= pix_in.red;
      main_g <= pix_in.green;
      main_b <= pix_in.blue;
    end else begin
      spare_r <= pix_in.red;
      spare_g <= pix_in.green;
      spare_b <= pix_in.blue;
    end
  end

  assign rgb.valid = main_valid;
  assign rgb.red   = main_r;
  assign rgb.green = main_g;
  assign rgb.blue  = main_b;

endmodule

// ===== src/hsv_to_rgb_color.sv =====
// HSV to RGB converter, top level. An accepted beat passes through stages A to H
// and the skid buffer's main register to the output. Throughput is one beat per
// cycle while the skid buffer's spare entry is empty; the eight arithmetic stages
// and the output skid buffer all move together, gated by its registered space flag.
// Reset (rst, synchronous) empties the pipeline and sets saturation to 1.0 (256).
module hsv_to_rgb_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [hsv2rgb_pkg::Q8_W-1:0]  wr_data,
  hsv_if.sink                           hsv,
  rgb_if.source                         rgb
);
  import hsv2rgb_pkg::*;

  // The saturation register is sampled into the pipeline together with each beat,
  // so it only has to be stable while a beat enters. The user must write it while the
  // block is idle, which it does not enforce; then beats already in flight see no hazard.
  logic [Q8_W-1:0] saturation;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= FULL_Q8;
    end else if (wr_en) begin
      saturation <= wr_data;
    end
  end

  // One advance signal drives every stage. It comes straight from a flip-flop
  // in the skid buffer, so the input ready never depends on the output ready
  // through logic. When the skid buffer's spare entry is full the whole pipeline
  // holds, bubbles included, and nothing is lost or repeated.
  logic     adv;
  hsv_sec_t sec;
  hsv_num_t num;
  rgb_pix_t pix;

  assign hsv.ready = adv;

  // Stages A to C: hue modulo 360 by reciprocal multiply, then the sector and
  // the remainder within the sector. Saturation and brightness are clamped to 1.0.
  hsv2rgb_hue_wrap u_hue_wrap (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (hsv.valid),
    .hue      (hsv.hue_degrees),
    .val_in   (hsv.brightness),
    .sat_in   (saturation),
    .sec_out  (sec)
  );

  // Stages D and E: exact numerators of v, p, q and t over 256 * 256 * 60.
  hsv2rgb_terms u_terms (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .sec_in  (sec),
    .num_out (num)
  );

  // Stages F to H: scale each numerator by 255 with truncation, then route the
  // four terms onto red, green and blue according to the sector.
  hsv2rgb_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .num_in  (num),
    .pix_out (pix)
  );

  // Output register with a spare entry, which parts the two handshakes.
  hsv2rgb_skid u_skid (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix),
    .adv    (adv),
    .rgb    (rgb)
  );

endmodule

// ===== src/hsv2rgb_check.sv =====
// Port-level checker for hsv_to_rgb_color, with the bind that attaches it.
// Depends on hsv2rgb_pkg for the channel width.
module hsv2rgb_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hsv2rgb_pkg::CH_W-1:0]  red,
  input logic [hsv2rgb_pkg::CH_W-1:0]  green,
  input logic [hsv2rgb_pkg::CH_W-1:0]  blue
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("output beat changed while stalled");

  // Reset leaves no output beat behind.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Input back-pressure only happens with a beat waiting at the output.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output");

  // Ready can only drop after an output beat was presented and not taken.
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input ready fell without an output stall");

endmodule

bind hsv_to_rgb_color hsv2rgb_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red       (rgb.red),
  .green     (rgb.green),
  .blue      (rgb.blue)
);

// ===== bench/hsv_to_rgb_color_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the HSV to RGB converter: directed corners, then random pixels.
// Depends on hsv2rgb_pkg, the hsv_if/rgb_if channel interfaces and hsv_to_rgb_color.
module hsv_to_rgb_color_tb;
  import hsv2rgb_pkg::*;

  // Arithmetic constants of the colour conversion; all but TURN_DEG are kept 64
  // bits wide so that the exact numerators never overflow.
  localparam int              TURN_DEG   = 360;
  localparam longint unsigned SECTOR_DEG = 60;
  localparam longint unsigned UNIT_Q8    = 256;
  localparam longint unsigned LEVEL_MAX  = 255;
  localparam longint unsigned COMMON_DEN = UNIT_Q8 * UNIT_Q8 * SECTOR_DEG;

  localparam int  DIRECTED_ROWS = 22;
  localparam int  RANDOM_FIRST  = 190;  // random pixels at the reset saturation
  localparam int  RANDOM_PHASE  = 165;  // random pixels per later saturation
  localparam int  SAT_PHASES    = 7;
  localparam int  SETTLE_CYCLES = 20;   // pipeline is nine deep; leave margin
  localparam real RUN_LIMIT_NS  = 5.0e6;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  // One directed pixel. When known is set, color holds the answer read
  // straight off the conversion; otherwise the predictor supplies it.
  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [Q8_W-1:0]         level;
    logic                    known;
    color_t                  color;
  } pixel_row_t;

  // Receiver behavior: always taking beats, taking most of them, or mostly stalled.
  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_e;

  logic clk;
  logic rst;
  logic wr_en;
  logic [Q8_W-1:0] wr_data;

  hsv_if hsv_ch ();
  rgb_if rgb_ch ();

  hsv_to_rgb_color u_top (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .hsv     (hsv_ch),
    .rgb     (rgb_ch)
  );

  // Shadow of the saturation register, as the converter should hold it.
  logic [Q8_W-1:0] sat_shadow;

  // Colours still owed by the converter, oldest first.
  color_t pending_colors [$];
  int     mismatches;

  // Side information that travels with the beat on the input channel, so the
  // checker knows whether a typed-in answer replaces the predicted one.
  logic   row_known;
  color_t row_color;

  int       burst_left;
  rx_mode_e rx_mode;
  int       rx_left;

  pixel_row_t directed [DIRECTED_ROWS] = '{
    // Primary and secondary colours at the sector boundaries, full value and
    // full saturation: each channel is either 0 or 255.
    {16'sd0,      9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
    {16'sd60,     9'd256, 1'b1, 8'd255, 8'd255, 8'd0},
    {16'sd120,    9'd256, 1'b1, 8'd0,   8'd255, 8'd0},
    {16'sd180,    9'd256, 1'b1, 8'd0,   8'd255, 8'd255},
    {16'sd240,    9'd256, 1'b1, 8'd0,   8'd0,   8'd255},
    {16'sd300,    9'd256, 1'b1, 8'd255, 8'd0,   8'd255},
    // A full turn and a negative full turn both land back on red.
    {16'sd360,    9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
    {-16'sd360,   9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
    // Zero brightness blacks out every channel, whatever the hue.
    {16'sd0,      9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    {16'sd200,    9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    // Most negative hue together with the all-ones brightness code.
    {16'sh8000,   9'd511, 1'b0, 24'd0},
    // Negative hue wrapping upward, and the ends of the hue range.
    {-16'sd1,     9'd256, 1'b0, 24'd0},
    {16'sd32767,  9'd256, 1'b0, 24'd0},
    {16'sh8000,   9'd256, 1'b0, 24'd0},
    // Brightness above one is clamped.
    {16'sd90,     9'd511, 1'b0, 24'd0},
    {16'sd90,     9'd257, 1'b0, 24'd0},
    // Degrees at and around sector ends, a mid-sector hue, and brightness from 1 to 256.
    {16'sd359,    9'd256, 1'b0, 24'd0},
    {16'sd59,     9'd128, 1'b0, 24'd0},
    {16'sd61,     9'd1,   1'b0, 24'd0},
    {16'sd30,     9'd255, 1'b0, 24'd0},
    // Alternating bit patterns on both fields.
    {16'sh5555,   9'h0AA, 1'b0, 24'd0},
    {16'shAAAA,   9'h155, 1'b0, 24'd0}
  };

  // Scales an exact numerator over COMMON_DEN to an 8-bit channel, truncating.
  function automatic logic [CH_W-1:0] channel_level(input longint unsigned num);
    return CH_W'((num * LEVEL_MAX) / COMMON_DEN);
  endfunction

  // Expected colour for one pixel at the given saturation code.
  function automatic color_t hsv_color_of(input logic signed [HUE_W-1:0] hue,
                                          input logic [Q8_W-1:0] level,
                                          input logic [Q8_W-1:0] sat_code);
    int              deg;
    longint unsigned s;
    longint unsigned v;
    longint unsigned rem;
    logic [2:0]      sector;
    logic [CH_W-1:0] cv, cp, cq, ct;
    color_t          c;
    // Reduce the angle; the remainder of a negative angle is negative, so fold it up.
    deg = int'(hue) % TURN_DEG;
    if (deg < 0) begin
      deg = deg + TURN_DEG;
    end
    s = (sat_code > UNIT_Q8) ? UNIT_Q8 : longint'(sat_code);
    v = (level > UNIT_Q8) ? UNIT_Q8 : longint'(level);
    sector = 3'(deg / int'(SECTOR_DEG));
    rem = longint'(deg % int'(SECTOR_DEG));
    cv = channel_level(v * UNIT_Q8 * SECTOR_DEG);
    cp = channel_level(v * (UNIT_Q8 - s) * SECTOR_DEG);
    cq = channel_level(v * (UNIT_Q8 * SECTOR_DEG - s * rem));
    ct = channel_level(v * (UNIT_Q8 * SECTOR_DEG - s * (SECTOR_DEG - rem)));
    case (sector)
      SECTOR_1: c = '{cq, cv, cp};
      SECTOR_2: c = '{cp, cv, ct};
      SECTOR_3: c = '{cp, cq, cv};
      SECTOR_4: c = '{ct, cp, cv};
      SECTOR_5: c = '{cv, cp, cq};
      default:  c = '{cv, ct, cp};
    endcase
    return c;
  endfunction

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Scoreboard. Everything is sampled at the rising edge, where the bench's
  // own inputs have been stable since the falling edge and the converter's
  // outputs still show their pre-edge values.
  always @(posedge clk) begin
    color_t got;
    color_t want;
    if (!rst && hsv_ch.valid && hsv_ch.ready) begin
      if (row_known) begin
        pending_colors = {pending_colors, row_color};
      end else begin
        pending_colors = {pending_colors,
                          hsv_color_of(hsv_ch.hue_degrees, hsv_ch.brightness, sat_shadow)};
      end
    end
    if (!rst && rgb_ch.valid && rgb_ch.ready) begin
      got = '{rgb_ch.red, rgb_ch.green, rgb_ch.blue};
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected output beat r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
          mismatches++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
          mismatches++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
          mismatches++;
        end
      end
    end
  end

  // Output back-pressure. The receiver switches between modes of random
  // length: open stretches take every beat, choppy ones drop ready about a
  // quarter of the time, and choked ones let only the odd beat through, which
  // fills the skid buffer and stalls the whole pipeline.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   rgb_ch.ready = 1'b1;
      RX_CHOPPY: rgb_ch.ready = ($urandom_range(0, 3) != 0);
      default:   rgb_ch.ready = ($urandom_range(0, 4) == 0);
    endcase
  end

  // Presents one pixel and holds it until the converter takes it. The sender
  // works in bursts; between bursts it drops valid for a random gap, and
  // some bursts follow on with no gap at all.
  task automatic send_pixel(input logic signed [HUE_W-1:0] hue, input logic [Q8_W-1:0] level,
                            input logic known, input color_t color);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < gap; i++) begin
        @(negedge clk);
        hsv_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 32);
    end
    @(negedge clk);
    hsv_ch.valid       = 1'b1;
    hsv_ch.hue_degrees = hue;
    hsv_ch.brightness  = level;
    row_known          = known;
    row_color          = color;
    do begin
      @(posedge clk);
    end while (!(hsv_ch.valid && hsv_ch.ready));
    burst_left--;
  endtask

  // Drops valid and waits until every owed colour has come out.
  task automatic drain_pipeline();
    @(negedge clk);
    hsv_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_colors.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes the saturation register while the converter is idle.
  task automatic write_saturation(input logic [Q8_W-1:0] sat_code);
    drain_pipeline();
    wr_en   = 1'b1;
    wr_data = sat_code;
    @(negedge clk);
    wr_en      = 1'b0;
    sat_shadow = sat_code;
  endtask

  // Random pixel. Hues cluster around sector boundaries and small negative
  // angles as well as covering the whole 16-bit range; brightness is mostly
  // in range, with its own corners and some clamped codes.
  task automatic send_random_pixel();
    int                      pick;
    int                      angle;
    logic signed [HUE_W-1:0] hue;
    logic [Q8_W-1:0]         level;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      angle = $urandom_range(0, TURN_DEG - 1);
    end else if (pick < 5) begin
      angle = 60 * $urandom_range(0, 12) + $urandom_range(0, 2) - 1;
    end else if (pick < 7) begin
      angle = -$urandom_range(1, 2 * TURN_DEG);
    end else begin
      angle = $urandom_range(0, 65535);
    end
    hue = HUE_W'(angle);
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      level = Q8_W'($urandom_range(0, 256));
    end else if (pick < 17) begin
      case ($urandom_range(0, 2))
        0:       level = 9'd0;
        1:       level = 9'd255;
        default: level = 9'd256;
      endcase
    end else begin
      level = Q8_W'($urandom_range(257, 511));
    end
    send_pixel(hue, level, 1'b0, '0);
  endtask

  // Saturation settings after the reset value: none, the all-ones code,
  // just above one, half, the smallest step, just below one, and one random.
  logic [Q8_W-1:0] sat_plan [SAT_PHASES];

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    wr_en      = 1'b0;
    wr_data    = '0;
    sat_shadow = 9'd256;
    mismatches = 0;
    burst_left = 0;
    rx_left    = 0;
    rx_mode    = RX_OPEN;
    row_known  = 1'b0;
    row_color  = '0;
    hsv_ch.valid       = 1'b0;
    hsv_ch.hue_degrees = '0;
    hsv_ch.brightness  = '0;
    rgb_ch.ready       = 1'b0;
    sat_plan = '{9'd0, 9'd511, 9'd257, 9'd128, 9'd1, 9'd255, 9'd0};
    sat_plan[SAT_PHASES-1] = Q8_W'($urandom_range(0, 511));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners run at the reset saturation of 1.0.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_pixel(directed[i].hue, directed[i].level, directed[i].known, directed[i].color);
    end
    for (int i = 0; i < RANDOM_FIRST; i++) begin
      send_random_pixel();
    end

    for (int p = 0; p < SAT_PHASES; p++) begin
      write_saturation(sat_plan[p]);
      for (int i = 0; i < RANDOM_PHASE; i++) begin
        send_random_pixel();
      end
    end

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("hsv_to_rgb_color_tb: PASS");
    end else begin
      $display("hsv_to_rgb_color_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT_NS);
    $display("hsv_to_rgb_color_tb: FAIL");
    $finish;
  end

endmodule
